// File: rtl/core/vfc_pkg.sv
// Shared types and constants for the voxel face culler.
package vfc_pkg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    localparam int FACE_COUNT = 6;

    typedef logic [2:0]            t_face;
    typedef logic [FACE_COUNT-1:0] t_mask;
    typedef logic [2:0]            t_step;

    localparam t_face FACE_TOP    = 3'd0;
    localparam t_face FACE_BOTTOM = 3'd1;
    localparam t_face FACE_FRONT  = 3'd2;
    localparam t_face FACE_BACK   = 3'd3;
    localparam t_face FACE_RIGHT  = 3'd4;
    localparam t_face FACE_LEFT   = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CULL  = 1'b1;

    // read sequence: center read at step 0, neighbors at steps 1..6,
    // center data back at step 1, last neighbor data back at step 7
    localparam t_step STEP_CENTER    = 3'd0;
    localparam t_step STEP_KIND      = 3'd1;
    localparam t_step STEP_FIRST_NBR = 3'd2;
    localparam t_step STEP_LAST      = 3'd7;

endpackage

// File: rtl/core/voxel_face_cull.sv
// Voxel face culler: cell store, neighbor probe sequencer and face output stage.
// Write item: no result. Cull item: accepted, then the center and
//   six neighbors read over the one store port, then one face per cycle while
//   i_stall is low. Air cell: no faces. Solid cell: a face per exposed side, first
//   on o_valid after the last neighbor read. After reset the store clears one entry
//   a cycle, SIZE_X*SIZE_Y*HEIGHT (65536 by default) entries, o_stall high till done.
module voxel_face_cull #(
    parameter int SIZE_X    = 16,
    parameter int SIZE_Y    = 16,
    parameter int HEIGHT    = 256,
    parameter int TYPE_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [3:0]         i_cell_x,
    input  logic [3:0]         i_cell_y,
    input  logic [7:0]         i_cell_height,
    input  logic [7:0]         i_write_type,
    input  logic signed [15:0] i_chunk_x,
    input  logic signed [15:0] i_chunk_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [19:0] o_world_x,
    output logic [7:0]         o_world_height,
    output logic signed [19:0] o_world_z,
    output vfc_pkg::t_face     o_face,
    output logic [7:0]         o_block_kind,
    output logic               o_last_face
);

    import vfc_pkg::*;

    localparam int DEPTH  = SIZE_X * SIZE_Y * HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [ADDR_W-1:0] OFS_H = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] OFS_Y = ADDR_W'(HEIGHT);
    localparam logic [ADDR_W-1:0] OFS_X = ADDR_W'(SIZE_Y * HEIGHT);

    t_state                r_state, n_state;
    t_step                 r_step, n_step;
    logic [ADDR_W-1:0]     r_clr, n_clr;
    logic [ADDR_W-1:0]     r_base, n_base;
    logic [3:0]            r_x, n_x;
    logic [3:0]            r_y, n_y;
    logic [7:0]            r_h, n_h;
    logic [19:0]           r_wx, n_wx;
    logic [19:0]           r_wz, n_wz;
    logic [TYPE_BITS-1:0]  r_kind, n_kind;
    t_mask                 r_mask, n_mask;

    logic                  r_out_v, n_out_v;
    logic [19:0]           r_o_wx, n_o_wx;
    logic [19:0]           r_o_wz, n_o_wz;
    logic [7:0]            r_o_h, n_o_h;
    t_face                 r_o_face, n_o_face;
    logic [7:0]            r_o_kind, n_o_kind;
    logic                  r_o_last, n_o_last;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [TYPE_BITS-1:0]  ram_wdata;
    logic [TYPE_BITS-1:0]  ram_rdata;

    logic                  w_accept;
    logic                  w_in_range;
    logic [ADDR_W-1:0]     w_in_addr;
    logic [19:0]           w_cx20, w_cy20;
    t_mask                 w_bound;
    t_face                 w_iss_face;
    t_face                 w_cap_face;
    logic [ADDR_W-1:0]     w_probe_addr;
    t_face                 w_pick;
    logic                  w_found;
    t_mask                 w_rest;

    vfc_ram #(
        .WIDTH (TYPE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    assign w_in_range = (32'(i_cell_x) < SIZE_X) && (32'(i_cell_y) < SIZE_Y)
                     && (32'(i_cell_height) < HEIGHT);
    assign w_in_addr  = ADDR_W'((32'(i_cell_x) * SIZE_Y + 32'(i_cell_y)) * HEIGHT
                     + 32'(i_cell_height));

    assign w_cx20 = {{4{i_chunk_x[15]}}, i_chunk_x};
    assign w_cy20 = {{4{i_chunk_y[15]}}, i_chunk_y};

    always_comb begin
        w_bound              = '0;
        w_bound[FACE_TOP]    = (32'(r_h) == HEIGHT - 1);
        w_bound[FACE_BOTTOM] = (r_h == '0);
        w_bound[FACE_FRONT]  = (32'(r_y) == SIZE_Y - 1);
        w_bound[FACE_BACK]   = (r_y == '0);
        w_bound[FACE_RIGHT]  = (32'(r_x) == SIZE_X - 1);
        w_bound[FACE_LEFT]   = (r_x == '0);
    end

    assign w_iss_face = t_face'(r_step - STEP_KIND);
    assign w_cap_face = t_face'(r_step - STEP_FIRST_NBR);

    // boundary probes read the center again, never outside the chunk
    always_comb begin
        w_probe_addr = r_base;
        if (r_step != STEP_CENTER && !w_bound[w_iss_face]) begin
            case (w_iss_face)
                FACE_TOP:    w_probe_addr = r_base + OFS_H;
                FACE_BOTTOM: w_probe_addr = r_base - OFS_H;
                FACE_FRONT:  w_probe_addr = r_base + OFS_Y;
                FACE_BACK:   w_probe_addr = r_base - OFS_Y;
                FACE_RIGHT:  w_probe_addr = r_base + OFS_X;
                FACE_LEFT:   w_probe_addr = r_base - OFS_X;
                default:     w_probe_addr = r_base;
            endcase
        end
    end

    always_comb begin
        w_pick  = FACE_TOP;
        w_found = 1'b0;
        for (int i = 0; i < FACE_COUNT; i++) begin
            if (r_mask[i] && !w_found) begin
                w_pick  = t_face'(i);
                w_found = 1'b1;
            end
        end
        w_rest = r_mask & ~(t_mask'(1) << w_pick);
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_clr    = r_clr;
        n_base   = r_base;
        n_x      = r_x;
        n_y      = r_y;
        n_h      = r_h;
        n_wx     = r_wx;
        n_wz     = r_wz;
        n_kind   = r_kind;
        n_mask   = r_mask;
        n_out_v  = r_out_v;
        n_o_wx   = r_o_wx;
        n_o_wz   = r_o_wz;
        n_o_h    = r_o_h;
        n_o_face = r_o_face;
        n_o_kind = r_o_kind;
        n_o_last = r_o_last;

        ram_we    = 1'b0;
        ram_addr  = r_base;
        ram_wdata = '0;

        if (r_out_v && !i_stall) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_addr = w_in_addr;
                if (w_accept && w_in_range) begin
                    if (i_opcode == OP_WRITE) begin
                        ram_we    = 1'b1;
                        ram_wdata = TYPE_BITS'(i_write_type);
                    end else begin
                        n_state = S_READ;
                        n_step  = STEP_CENTER;
                        n_base  = w_in_addr;
                        n_x     = i_cell_x;
                        n_y     = i_cell_y;
                        n_h     = i_cell_height;
                        n_wx    = 20'(w_cx20 * 20'(SIZE_X)) + {16'b0, i_cell_x};
                        n_wz    = 20'(w_cy20 * 20'(SIZE_Y)) + {16'b0, i_cell_y};
                        n_mask  = '0;
                    end
                end
            end
            S_READ: begin
                ram_addr = w_probe_addr;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_KIND) begin
                    n_kind = ram_rdata;
                    if (ram_rdata == '0) begin
                        n_state = S_IDLE;
                    end
                end else if (r_step >= STEP_FIRST_NBR) begin
                    n_mask[w_cap_face] = w_bound[w_cap_face] || (ram_rdata == '0);
                end
                if (r_step == STEP_LAST) begin
                    n_state = (n_mask == '0) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_v || !i_stall) begin
                    n_out_v  = 1'b1;
                    n_o_wx   = r_wx;
                    n_o_wz   = r_wz;
                    n_o_h    = r_h;
                    n_o_face = w_pick;
                    n_o_kind = 8'(r_kind);
                    n_o_last = (w_rest == '0);
                    n_mask   = w_rest;
                    if (w_rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= STEP_CENTER;
            r_clr   <= '0;
            r_mask  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_clr   <= n_clr;
            r_mask  <= n_mask;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_x      <= n_x;
        r_y      <= n_y;
        r_h      <= n_h;
        r_wx     <= n_wx;
        r_wz     <= n_wz;
        r_kind   <= n_kind;
        r_o_wx   <= n_o_wx;
        r_o_wz   <= n_o_wz;
        r_o_h    <= n_o_h;
        r_o_face <= n_o_face;
        r_o_kind <= n_o_kind;
        r_o_last <= n_o_last;
    end

    assign o_valid        = r_out_v;
    assign o_world_x      = r_o_wx;
    assign o_world_z      = r_o_wz;
    assign o_world_height = r_o_h;
    assign o_face         = r_o_face;
    assign o_block_kind   = r_o_kind;
    assign o_last_face    = r_o_last;

`ifndef NO_ASSERTIONS
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> o_stall && !o_valid && ram_we && ram_wdata == '0)
        else $error("store clear overlapped traffic");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !ram_we)
        else $error("store write during neighbor probe");

    a_emit_has_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_mask != '0)
        else $error("emit state with no face pending");

    a_last_ends_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && n_out_v && n_o_last && (!r_out_v || !i_stall)
        |=> r_state == S_IDLE)
        else $error("last face did not end the cell");
`endif

endmodule

// File: rtl/core/vfc_ram.sv
// Single-port synchronous RAM with registered read data.
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
